// ===== rtl/core/itfdd_pkg.sv =====
`default_nettype none
package itfdd_pkg;

   localparam int DIGITS_PER_HALF = 4;
   localparam int BCD_DIGITS      = 20;
   localparam int VALUE_WIDTH     = 64;
   localparam int STEPS_PER_STAGE = 8;
   localparam int DABBLE_STAGES   = VALUE_WIDTH / STEPS_PER_STAGE;

   localparam logic [4:0] SYM_L     = 5'd18;
   localparam logic [4:0] SYM_O     = 5'd20;
   localparam logic [4:0] SYM_MINUS = 5'd26;
   localparam logic [4:0] SYM_BLANK = 5'd27;
   localparam logic [4:0] SYM_ZERO  = 5'd0;

   typedef struct packed {
      logic       neg;
      logic [1:0] chip;
      logic       half;
   } side_type;

   typedef struct packed {
      logic [4*BCD_DIGITS-1:0] bcd;
      logic [VALUE_WIDTH-1:0]  bin;
      side_type                side;
   } dd_type;

   function automatic dd_type dabble_steps(input dd_type x);
      dd_type y;
      y = x;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (y.bcd[4*d +: 4] >= 4'd5) begin
               y.bcd[4*d +: 4] = y.bcd[4*d +: 4] + 4'd3;
            end
         end
         y.bcd = {y.bcd[4*BCD_DIGITS-2:0], y.bin[VALUE_WIDTH-1]};
         y.bin = {y.bin[VALUE_WIDTH-2:0], 1'b0};
      end
      return y;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/itfdd_dabble_stage.sv =====
`default_nettype none
module itfdd_dabble_stage
   import itfdd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_valid,
   input  wire dd_type in_data,
   output logic        out_valid,
   output dd_type      out_data
);

   logic   valid_ff;
   dd_type data_ff;
   dd_type data_in;

   assign data_in = dabble_steps(in_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/integer_to_four_digit_display.sv =====
`default_nettype none
// Channel  Direction  tdata fields (low bit up)                          tlast
// req      in         value[63:0] chip_sel[65:64] half[67:66]            -
// rsp      out        chip_out[1:0] digit_reg[5:2] symbol[10:6] point[11] last
//
// An item passes an input register, eight conversion stages of eight
// shift-and-correct steps each, and then a symbol stage that loads the writer.
// Each accepted item with half 0 or 1 yields four write transactions on the
// single output port, and the pipeline holds until the last of them is taken.
// A half above one is dropped at the input register. Reset is synchronous and
// clears every valid bit. A stalled output holds the whole pipeline.
module integer_to_four_digit_display
   import itfdd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // value, chip_sel, half
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // chip_out, digit_reg, symbol, point
   output logic             rsp_tlast
);

   logic   en;
   logic   in_valid_ff;
   dd_type in_data_ff;
   dd_type in_data_in;

   logic   st_valid [DABBLE_STAGES+1];
   dd_type st_data  [DABBLE_STAGES+1];

   logic       out_valid_ff;
   logic [1:0] pos_ff;
   logic [4:0] sym_ff [DIGITS_PER_HALF];
   logic [4:0] sym_in [DIGITS_PER_HALF];
   logic [DIGITS_PER_HALF-1:0] pt_ff;
   logic [DIGITS_PER_HALF-1:0] pt_in;
   side_type   side_ff;

   logic [VALUE_WIDTH-1:0] raw;
   logic [3:0] dig [BCD_DIGITS];
   logic [4:0] n;
   logic [4:0] ex;
   logic [4:0] idx;
   logic       lead;
   logic [2:0] shown;
   logic [3:0] reg_addr;

   assign en         = !out_valid_ff || (rsp_tready && pos_ff == 2'd3);
   assign req_tready = en;

   always_comb begin
      raw                  = req_tdata[63:0];
      in_data_in.bcd       = '0;
      in_data_in.bin       = raw[63] ? (~raw + 64'd1) : raw;
      in_data_in.side.neg  = raw[63];
      in_data_in.side.chip = req_tdata[65:64];
      in_data_in.side.half = req_tdata[66];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid && !req_tdata[67];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_data_ff <= in_data_in;
      end
   end

   assign st_valid[0] = in_valid_ff;
   assign st_data[0]  = in_data_ff;

   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
      itfdd_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (st_valid[g]),
         .in_data   (st_data[g]),
         .out_valid (st_valid[g+1]),
         .out_data  (st_data[g+1])
      );
   end

   always_comb begin
      n = '0;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         dig[d] = st_data[DABBLE_STAGES].bcd[4*d +: 4];
         if (dig[d] != 4'd0) begin
            n = 5'(d + 1);
         end
      end
      lead  = st_data[DABBLE_STAGES].side.neg;
      shown = lead ? 3'd3 : 3'd4;
      ex    = n - {2'b00, shown};
      pt_in = '0;
      idx   = '0;
      for (int i = 0; i < DIGITS_PER_HALF; i++) begin
         sym_in[i] = SYM_ZERO;
      end
      if (lead && n >= 5'd19) begin
         sym_in[0] = SYM_MINUS;
         sym_in[1] = SYM_BLANK;
         sym_in[2] = SYM_L;
         sym_in[3] = SYM_O;
      end else if (n != 5'd0) begin
         if (lead) begin
            sym_in[0] = SYM_MINUS;
         end
         if (n < {2'b00, shown}) begin
            for (int i = 0; i < DIGITS_PER_HALF; i++) begin
               if (i >= 1 || !lead) begin
                  if (5'(DIGITS_PER_HALF - 1 - i) < n) begin
                     sym_in[i] = {1'b0, dig[DIGITS_PER_HALF - 1 - i]};
                  end
               end
            end
         end else begin
            for (int i = 0; i < DIGITS_PER_HALF; i++) begin
               if (i >= 1 || !lead) begin
                  idx = n - 5'd1 - 5'(i) + {4'd0, lead};
                  sym_in[i] = {1'b0, dig[idx]};
               end
               pt_in[i] = ex[DIGITS_PER_HALF - 1 - i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else if (en) begin
         out_valid_ff <= st_valid[DABBLE_STAGES];
         pos_ff       <= '0;
      end else if (rsp_tready) begin
         pos_ff <= pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIGITS_PER_HALF; i++) begin
            sym_ff[i] <= sym_in[i];
         end
         pt_ff   <= pt_in;
         side_ff <= st_data[DABBLE_STAGES].side;
      end
   end

   assign reg_addr   = {1'b0, side_ff.half, 2'b00} + {2'b00, pos_ff} + 4'd1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (pos_ff == 2'd3);
   assign rsp_tdata  = {4'd0, pt_ff[pos_ff], sym_ff[pos_ff], reg_addr, side_ff.chip};

`ifndef NO_ASSERTIONS
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("write run broke off before its last transaction");

   a_addr_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tdata[5:2] == $past(rsp_tdata[5:2]) + 4'd1)
      else $error("digit register address did not advance by one");

   a_no_take_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken while a write run is unfinished");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
